FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define RMSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RMSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rmsf_pkg.sv
// shared types and constants for the row mirror / sepia filter
// no dependencies
`default_nettype none

package rmsf_pkg;

  localparam int PIX_W = 24;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       row_last;
    logic       frame_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       run_last;
    logic       row_end;
    logic       frame_end;
  } result_t;

  // one queue entry: a pass-through pixel or a row-close marker
  typedef struct packed {
    logic   is_row;
    pixel_t pix;
  } cmd_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPIA  = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // sepia matrix, Q0.16, [output channel][input channel], order red, green, blue
  localparam logic [2:0][2:0][15:0] SEPIA_COEF = '{
    '{16'd8585,  16'd34996, 16'd17826},
    '{16'd11010, 16'd44958, 16'd22872},
    '{16'd12386, 16'd50397, 16'd25756}
  };

endpackage

`default_nettype wire

FILE: hw/rtl/rmsf_line_buf.sv
// row storage: one write port, one registered read port
// depends on rmsf_pkg
`default_nettype none

module rmsf_line_buf #(
  parameter int MAX_ROW_PIXELS = 64,
  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [rmsf_pkg::PIX_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [rmsf_pkg::PIX_W-1:0] rd_data
);
  import rmsf_pkg::*;

  logic [PIX_W-1:0] mem [MAX_ROW_PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rmsf_queue.sv
// short command queue between front and back
// depends on rmsf_pkg
`default_nettype none

module rmsf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rmsf_pkg::cmd_t cmd_in,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output rmsf_pkg::cmd_t     cmd_out
);
  import rmsf_pkg::*;

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rmsf_front.sv
// input side: takes pixels, fills the row store, queues commands
// depends on rmsf_pkg
`default_nettype none

module rmsf_front #(
  parameter int MAX_ROW_PIXELS = 64,
  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1,
  localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       mirror,
  input  wire logic                       pix_valid,
  input  wire rmsf_pkg::pixel_t           pix,
  output logic                            pix_stall,
  input  wire logic                       q_full,
  output logic                            q_push,
  output rmsf_pkg::cmd_t                  q_cmd,
  output logic                            wr_en,
  output logic      [AW-1:0]              wr_addr,
  output logic      [rmsf_pkg::PIX_W-1:0] wr_data,
  output logic      [CW-1:0]              row_len,
  input  wire logic                       drain_done
);
  import rmsf_pkg::*;

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_inc;
  logic          busy;
  logic          accept;
  logic          can_store;
  logic          close;

  always_comb begin
    pix_stall = q_full || busy;
    accept    = pix_valid && !pix_stall;
    can_store = (fill < CW'(MAX_ROW_PIXELS));
    close     = pix.row_last || pix.frame_last;
    fill_inc  = fill + 1'b1;

    q_push       = accept && (!mirror || close);
    q_cmd.is_row = mirror;
    q_cmd.pix    = pix;

    wr_en   = accept && mirror && can_store;
    wr_addr = fill[AW-1:0];
    wr_data = {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      busy <= 1'b0;
    end else begin
      if (accept) begin
        if (!mirror || close) begin
          fill <= '0;
        end else if (can_store) begin
          fill <= fill_inc;
        end
      end
      // store is locked from row close until the back has read it out
      if (accept && mirror && close) begin
        busy <= 1'b1;
      end else if (drain_done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && mirror && close) begin
      row_len <= can_store ? fill_inc : fill;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rmsf_back.sv
// output side: reverse row readout, sepia matrix, output register
// depends on rmsf_pkg
`default_nettype none

module rmsf_back #(
  parameter int MAX_ROW_PIXELS = 64,
  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1,
  localparam int CW = $clog2(MAX_ROW_PIXELS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       sepia,
  input  wire logic                       q_valid,
  input  wire rmsf_pkg::cmd_t             q_cmd,
  output logic                            q_pop,
  input  wire logic      [CW-1:0]         row_len,
  output logic                            rd_en,
  output logic      [AW-1:0]              rd_addr,
  input  wire logic [rmsf_pkg::PIX_W-1:0] rd_data,
  output logic                            drain_done,
  output logic                            res_valid,
  input  wire logic                       res_stall,
  output rmsf_pkg::result_t               res
);
  import rmsf_pkg::*;

  logic          adv;
  logic          draining;
  logic [AW-1:0] cur;
  logic          drain_frame;
  logic [CW-1:0] len_m1;
  logic          issue_pass;
  logic          issue_mem;
  logic          mem_last;

  // stage 1: issued item
  logic            s1_valid;
  logic            s1_is_mem;
  logic [2:0][7:0] s1_pix;
  logic            s1_run_last;
  logic            s1_row_end;
  logic            s1_frame_end;
  logic [2:0][7:0] s1_px;

  // stage 2: products
  logic                   s2_valid;
  logic [2:0][7:0]        s2_raw;
  logic [2:0][2:0][23:0]  s2_prod;
  logic                   s2_run_last;
  logic                   s2_row_end;
  logic                   s2_frame_end;

  logic [2:0][25:0] sum;
  logic [2:0][7:0]  sep;

  always_comb begin
    adv        = !res_valid || !res_stall;
    q_pop      = adv && !draining && q_valid;
    issue_pass = q_pop && !q_cmd.is_row;
    issue_mem  = adv && draining;
    mem_last   = (cur == '0);
    rd_en      = issue_mem;
    rd_addr    = cur;
    drain_done = issue_mem && mem_last;
    len_m1     = row_len - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (q_pop && q_cmd.is_row) begin
      draining <= 1'b1;
    end else if (drain_done) begin
      draining <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.is_row) begin
      cur         <= len_m1[AW-1:0];
      drain_frame <= q_cmd.pix.frame_last;
    end else if (issue_mem && !mem_last) begin
      cur <= cur - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue_pass || issue_mem;
      s2_valid  <= s1_valid;
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_is_mem    <= issue_mem;
      s1_pix[0]    <= q_cmd.pix.pixel_red;
      s1_pix[1]    <= q_cmd.pix.pixel_green;
      s1_pix[2]    <= q_cmd.pix.pixel_blue;
      s1_run_last  <= issue_mem ? mem_last : 1'b1;
      s1_row_end   <= issue_mem ? mem_last : q_cmd.pix.row_last;
      s1_frame_end <= issue_mem ? (mem_last && drain_frame) : q_cmd.pix.frame_last;
    end
  end

  always_comb begin
    if (s1_is_mem) begin
      s1_px[0] = rd_data[23:16];
      s1_px[1] = rd_data[15:8];
      s1_px[2] = rd_data[7:0];
    end else begin
      s1_px = s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_raw       <= s1_px;
      s2_run_last  <= s1_run_last;
      s2_row_end   <= s1_row_end;
      s2_frame_end <= s1_frame_end;
      for (int o = 0; o < 3; o++) begin
        for (int i = 0; i < 3; i++) begin
          s2_prod[o][i] <= 24'(SEPIA_COEF[o][i]) * 24'(s1_px[i]);
        end
      end
    end
  end

  always_comb begin
    for (int o = 0; o < 3; o++) begin
      sum[o] = 26'(s2_prod[o][0]) + 26'(s2_prod[o][1]) + 26'(s2_prod[o][2]);
      sep[o] = (sum[o][25:16] > 10'd255) ? 8'hFF : sum[o][23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.out_red   <= sepia ? sep[0] : s2_raw[0];
      res.out_green <= sepia ? sep[1] : s2_raw[1];
      res.out_blue  <= sepia ? sep[2] : s2_raw[2];
      res.run_last  <= s2_run_last;
      res.row_end   <= s2_row_end;
      res.frame_end <= s2_frame_end;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/row_mirror_sepia_filter.sv
// top level of the row mirror / sepia filter
// depends on rmsf_pkg, rmsf_front, rmsf_queue, rmsf_line_buf, rmsf_back
`default_nettype none

// RGB888 pixels come in one word per cycle in raster order while pix_stall is
// low. With mirror_enable clear, every pixel gives one result word, passed
// through the command queue, stage 1, stage 2 and the output register; a new
// pixel is taken every cycle while the four-entry command queue has room. With
// mirror_enable set, a row's pixels are taken one per cycle into the row store
// (up to MAX_ROW_PIXELS, the rest of a longer row is dropped) and produce no
// result; the pixel with row_last or frame_last closes the row. The input then
// stalls until the back end has read the stored row out right to left, one
// read per cycle from the single read port of the row store while the result
// side does not stall. sepia_enable runs every result through the sepia matrix,
// saturated to 255. No clearing pass is needed after reset.

module row_mirror_sepia_filter #(
  parameter int MAX_ROW_PIXELS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             pix_valid,
  output logic                                  pix_stall,
  input  wire rmsf_pkg::pixel_t                 pix,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output rmsf_pkg::result_t                     res,
  input  wire logic                             cfg_write,
  input  wire logic [rmsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic                             cfg_data
);
  import rmsf_pkg::*;

  localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int CW = $clog2(MAX_ROW_PIXELS + 1);

  logic             mirror_enable;
  logic             sepia_enable;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_cmd_in;
  cmd_t             q_cmd_out;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [PIX_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [PIX_W-1:0] rd_data;
  logic [CW-1:0]    row_len;
  logic             drain_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_enable <= 1'b0;
      sepia_enable  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIRROR: mirror_enable <= cfg_data;
        CFG_SEPIA:  sepia_enable  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rmsf_front #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .mirror     (mirror_enable),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .pix_stall  (pix_stall),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd_in),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .row_len    (row_len),
    .drain_done (drain_done)
  );

  rmsf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .cmd_out (q_cmd_out)
  );

  rmsf_line_buf #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rmsf_back #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .sepia      (sepia_enable),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd_out),
    .q_pop      (q_pop),
    .row_len    (row_len),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .drain_done (drain_done),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rmsf_checker.sv
// port-level checks for row_mirror_sepia_filter, bound to the top level
// depends on rmsf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rmsf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pix_stall,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire rmsf_pkg::result_t res
);
  import rmsf_pkg::*;

  `RMSF_ASSERT_ALWAYS(a_reset_idle, rst |=> !res_valid && !pix_stall, "not idle after reset")
  `RMSF_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "result word moved while stalled")
  `RMSF_ASSERT(a_flags, res_valid && !res.run_last |-> !res.row_end && !res.frame_end, "row or frame end inside a run")

endmodule

bind row_mirror_sepia_filter rmsf_checker u_rmsf_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

FILE: test/row_mirror_sepia_filter_tb.sv
// self-checking testbench for row_mirror_sepia_filter: directed table, then random rows
// predicts every result word from its own mirror / sepia model; needs rmsf_pkg and the rtl
module row_mirror_sepia_filter_tb;
  import rmsf_pkg::*;

  localparam int MAX_ROW = 64;
  localparam int SETTLE = MAX_ROW + 16;
  localparam int STALL_LIMIT = 4000;
  localparam int SEG_WORDS = 4;
  localparam int NUM_SEGS = 6;
  localparam int NUM_PLAN = 26;

  typedef enum logic {STEP_PIX, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] sel;
    int                   val;
    int                   r, g, b, rl, fl;
    int                   typed;
    int                   er, eg, eb, erun, erow, eframe;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  pixel_t               pix = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  result_t              res;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIRROR;
  logic                 cfg_data = 1'b0;

  logic        mirror_on = 1'b0;
  logic        sepia_on = 1'b0;
  logic [23:0] row_pixels [MAX_ROW];
  int          row_fill = 0;
  result_t     pending_results [$];

  int send_gap_pct = 18;
  int recv_hold_pct = 46;
  int words_in = 0;
  int words_out = 0;
  int rows_closed = 0;
  int bad_words = 0;
  int quiet_cycles = 0;

  // cfg rows use sel/val, pixel rows use r..fl and, where typed, the expected word
  plan_row_t plan [NUM_PLAN] = '{
    '{STEP_PIX, CFG_MIRROR, 0,   0,   0,   0, 0, 0, 1,   0,   0,   0, 1, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 255, 255, 255, 1, 0, 1, 255, 255, 255, 1, 1, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 170,  85,   1, 0, 1, 1, 170,  85,   1, 1, 0, 1},
    '{STEP_PIX, CFG_MIRROR, 0,  85, 170, 254, 1, 1, 1,  85, 170, 254, 1, 1, 1},
    '{STEP_CFG, CFG_SEPIA,  1,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 255, 255, 255, 1, 1, 1, 255, 255, 238, 1, 1, 1},
    '{STEP_PIX, CFG_MIRROR, 0,   0,   0,   0, 0, 0, 1,   0,   0,   0, 1, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,   0,   0, 255, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 255,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_CFG, CFG_MIRROR, 1,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,  10,  20,  30, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 200, 100,  50, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0, 255,   0, 128, 1, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_CFG, CFG_SEPIA,  0,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,   1,   2,   3, 1, 0, 1,   1,   2,   3, 1, 1, 0},
    // row closed by the frame mark alone
    '{STEP_PIX, CFG_MIRROR, 0,   4,   5,   6, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,   7,   8,   9, 0, 1, 0,   0,   0,   0, 0, 0, 0},
    // sepia switched on while a row is open
    '{STEP_PIX, CFG_MIRROR, 0,  11,  12,  13, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,  14,  15,  16, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_CFG, CFG_SEPIA,  1,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,  17,  18,  19, 1, 1, 0,   0,   0,   0, 0, 0, 0},
    // mirror switched off with a row open drops it
    '{STEP_PIX, CFG_MIRROR, 0,  21,  22,  23, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_CFG, CFG_MIRROR, 0,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,  30,  40,  50, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_CFG, CFG_MIRROR, 1,   0,   0,   0, 0, 0, 0,   0,   0,   0, 0, 0, 0},
    '{STEP_PIX, CFG_MIRROR, 0,  60,  70,  80, 1, 0, 0,   0,   0,   0, 0, 0, 0}
  };

  bit seg_mirror [NUM_SEGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
  bit seg_sepia  [NUM_SEGS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

  row_mirror_sepia_filter #(
    .MAX_ROW_PIXELS(MAX_ROW)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] clip8(logic [31:0] sum);
    logic [31:0] v;
    v = sum >> 16;
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic result_t tone_word(logic [23:0] px, logic run, logic rowe, logic frm);
    result_t     o;
    logic [31:0] r, g, b;
    r = {24'd0, px[23:16]};
    g = {24'd0, px[15:8]};
    b = {24'd0, px[7:0]};
    if (sepia_on) begin
      o.out_red   = clip8(25756 * r + 50397 * g + 12386 * b);
      o.out_green = clip8(22872 * r + 44958 * g + 11010 * b);
      o.out_blue  = clip8(17826 * r + 34996 * g + 8585 * b);
    end else begin
      o.out_red   = r[7:0];
      o.out_green = g[7:0];
      o.out_blue  = b[7:0];
    end
    o.run_last  = run;
    o.row_end   = rowe;
    o.frame_end = frm;
    return o;
  endfunction

  function automatic void predict_word(pixel_t w);
    logic [23:0] px;
    int          k;
    px = {w.pixel_red, w.pixel_green, w.pixel_blue};
    if (!mirror_on) begin
      row_fill = 0;
      pending_results.push_back(tone_word(px, 1'b1, w.row_last, w.frame_last));
      return;
    end
    if (row_fill < MAX_ROW) begin
      row_pixels[row_fill] = px;
      row_fill++;
    end
    if (!w.row_last && !w.frame_last) return;
    for (k = row_fill - 1; k >= 0; k--) begin
      pending_results.push_back(tone_word(row_pixels[k], k == 0, k == 0,
                                          (k == 0) && w.frame_last));
    end
    row_fill = 0;
    rows_closed++;
  endfunction

  function automatic logic [7:0] pick_chan();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'd0;
      1: v = 8'd255;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic send_word(input pixel_t w, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= w;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    predict_word(w);
    if (typed) pending_results[pending_results.size() - 1] = want;
    words_in++;
  endtask

  task automatic hold_until_drained();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic val);
    pix_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an open mirrored row leaves no word to wait on, so give the block time
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (sel == CFG_MIRROR) mirror_on = val;
    else sepia_on = val;
  endtask

  task automatic report_bad(input string why, input result_t want, input result_t got);
    bad_words++;
    if (bad_words <= 10) begin
      $display("%s: want r=%0d g=%0d b=%0d run=%0b row=%0b frame=%0b", why,
               want.out_red, want.out_green, want.out_blue,
               want.run_last, want.row_end, want.frame_end);
      $display("  got r=%0d g=%0d b=%0d run=%0b row=%0b frame=%0b",
               got.out_red, got.out_green, got.out_blue,
               got.run_last, got.row_end, got.frame_end);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    res_stall <= ($urandom_range(0, 99) < recv_hold_pct);
    if (!rst && res_valid && !res_stall) begin
      words_out++;
      if (pending_results.size() == 0) begin
        report_bad("unexpected word", '0, res);
      end else begin
        want = pending_results.pop_front();
        if (res.out_red !== want.out_red || res.out_green !== want.out_green ||
            res.out_blue !== want.out_blue || res.run_last !== want.run_last ||
            res.row_end !== want.row_end || res.frame_end !== want.frame_end)
          report_bad("mismatch", want, res);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d words pending",
                 STALL_LIMIT, pending_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    pixel_t  w;
    result_t want;
    int      i, seg, row_idx, seg_words, len, k;
    bit      frame_only;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NUM_PLAN; i++) begin
      if (plan[i].kind == STEP_CFG) begin
        write_reg(plan[i].sel, plan[i].val[0]);
      end else begin
        w.pixel_red     = plan[i].r[7:0];
        w.pixel_green   = plan[i].g[7:0];
        w.pixel_blue    = plan[i].b[7:0];
        w.row_last      = plan[i].rl[0];
        w.frame_last    = plan[i].fl[0];
        want.out_red    = plan[i].er[7:0];
        want.out_green  = plan[i].eg[7:0];
        want.out_blue   = plan[i].eb[7:0];
        want.run_last   = plan[i].erun[0];
        want.row_end    = plan[i].erow[0];
        want.frame_end  = plan[i].eframe[0];
        send_word(w, plan[i].typed != 0, want);
      end
    end

    for (seg = 0; seg < NUM_SEGS; seg++) begin
      write_reg(CFG_MIRROR, seg_mirror[seg]);
      write_reg(CFG_SEPIA, seg_sepia[seg]);
      case (seg / 2)
        0: begin
          send_gap_pct = 18;
          recv_hold_pct = 46;
        end
        1: begin
          send_gap_pct = 46;
          recv_hold_pct = 18;
        end
        default: begin
          send_gap_pct = 0;
          recv_hold_pct = 0;
        end
      endcase
      seg_words = 0;
      row_idx = 0;
      while (seg_words < SEG_WORDS) begin
        if (row_idx == 1 || $urandom_range(0, 7) == 0) hold_until_drained();
        if (row_idx == 0 && seg == 0) len = MAX_ROW;
        else if (row_idx == 0 && seg == 4) len = $urandom_range(MAX_ROW + 1, MAX_ROW + 6);
        else if ($urandom_range(0, 15) == 0) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        frame_only = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          w.pixel_red   = pick_chan();
          w.pixel_green = pick_chan();
          w.pixel_blue  = pick_chan();
          if (seg_mirror[seg]) begin
            w.row_last   = (k == len - 1) && !frame_only;
            w.frame_last = (k == len - 1) && (frame_only || $urandom_range(0, 3) == 0);
          end else begin
            w.row_last   = ($urandom_range(0, 3) == 0);
            w.frame_last = ($urandom_range(0, 5) == 0);
          end
          send_word(w, 1'b0, '0);
        end
        seg_words += len;
        row_idx++;
      end
    end

    pix_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d pixel words in, %0d result words checked, %0d mirrored rows closed",
             words_in, words_out, rows_closed);
    $display("all four mirror/sepia settings, rows from 1 to over %0d pixels", MAX_ROW);
    if (bad_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d bad result words", bad_words);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
